>>> hw/rtl/pntt_pkg.sv
package pntt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_REFRESH = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef logic [2:0] status_t;
    localparam status_t ST_DONE     = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_NO_ENTRY = 3'd2;
    localparam status_t ST_EXPIRED  = 3'd3;
    localparam status_t ST_NONE_DUE = 3'd4;

    typedef struct packed {
        op_t         op;
        logic [15:0] obj_handle;
        logic [15:0] res_number;
        logic [15:0] period;
        logic [47:0] now;
    } cmd_t;

    // now + period, clamped at the top of the 48-bit range
    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] p);
        logic [48:0] s;
        s = {1'b0, a} + {33'b0, p};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

endpackage

>>> hw/rtl/pntt_front.sv
module pntt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           req_type,
    input  logic [15:0]          obj_handle,
    input  logic [15:0]          res_number,
    input  logic [15:0]          period,
    input  logic [47:0]          now,
    output pntt_pkg::cmd_t       cmd,
    output logic                 cmd_valid,
    input  logic                 cmd_pop
);
    import pntt_pkg::*;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;
    cmd_t              in_cmd;

    // classify: request code becomes an operation
    always_comb
    begin
        in_cmd.op         = op_t'(req_type);
        in_cmd.obj_handle = obj_handle;
        in_cmd.res_number = res_number;
        in_cmd.period     = period;
        in_cmd.now        = now;
    end

    assign req_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> hw/rtl/pntt_back.sv
module pntt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  pntt_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output logic [2:0]     status,
    output logic [15:0]    fired_object,
    output logic [15:0]    fired_resource,
    output logic           last
);
    import pntt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    // slot table
    logic        used_reg [ENTRIES];
    logic        done_reg [ENTRIES];
    logic [15:0] obj_reg  [ENTRIES];
    logic [15:0] rsc_reg  [ENTRIES];
    logic [15:0] per_reg  [ENTRIES];
    logic [47:0] exp_reg  [ENTRIES];

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             mfound_reg, mfound_next;
    logic [IDX_W-1:0] midx_reg, midx_next;
    logic [15:0]      mper_reg, mper_next;
    logic             ffound_reg, ffound_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;
    logic             bfound_reg, bfound_next;
    logic [IDX_W-1:0] bidx_reg, bidx_next;
    logic [47:0]      bexp_reg, bexp_next;
    logic [15:0]      bobj_reg, bobj_next;
    logic [15:0]      brsc_reg, brsc_next;
    logic             fired_any_reg, fired_any_next;
    status_t          pst_reg, pst_next;
    logic [15:0]      pobj_reg, pobj_next;
    logic [15:0]      prsc_reg, prsc_next;
    logic             plast_reg, plast_next;
    logic             rsp_valid_reg, rsp_valid_next;
    status_t          status_reg, status_next;
    logic [15:0]      fobj_reg, fobj_next;
    logic [15:0]      frsc_reg, frsc_next;
    logic             last_reg, last_next;

    logic hit, due, load_out;
    logic add_wr, used_clr, exp_wr, done_clr, done_set;

    assign hit = used_reg[idx_reg] && (obj_reg[idx_reg] == cmd_reg.obj_handle)
                 && (rsc_reg[idx_reg] == cmd_reg.res_number);
    assign due = used_reg[idx_reg] && !done_reg[idx_reg]
                 && (cmd_reg.now >= exp_reg[idx_reg]);
    assign load_out = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        mfound_next    = mfound_reg;
        midx_next      = midx_reg;
        mper_next      = mper_reg;
        ffound_next    = ffound_reg;
        fidx_next      = fidx_reg;
        bfound_next    = bfound_reg;
        bidx_next      = bidx_reg;
        bexp_next      = bexp_reg;
        bobj_next      = bobj_reg;
        brsc_next      = brsc_reg;
        fired_any_next = fired_any_reg;
        pst_next       = pst_reg;
        pobj_next      = pobj_reg;
        prsc_next      = prsc_reg;
        plast_next     = plast_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        fobj_next      = fobj_reg;
        frsc_next      = frsc_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        add_wr         = 1'b0;
        used_clr       = 1'b0;
        exp_wr         = 1'b0;
        done_clr       = 1'b0;
        done_set       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd;
                    idx_next       = '0;
                    mfound_next    = 1'b0;
                    ffound_next    = 1'b0;
                    bfound_next    = 1'b0;
                    fired_any_next = 1'b0;
                    done_clr       = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit && !mfound_reg)
                begin
                    mfound_next = 1'b1;
                    midx_next   = idx_reg;
                    mper_next   = per_reg[idx_reg];
                end
                // a matching slot counts as free: add drops it first
                if ((!used_reg[idx_reg] || hit) && !ffound_reg)
                begin
                    ffound_next = 1'b1;
                    fidx_next   = idx_reg;
                end
                // strict less keeps the lower slot on equal expiry
                if (due && (!bfound_reg || (exp_reg[idx_reg] < bexp_reg)))
                begin
                    bfound_next = 1'b1;
                    bidx_next   = idx_reg;
                    bexp_next   = exp_reg[idx_reg];
                    bobj_next   = obj_reg[idx_reg];
                    brsc_next   = rsc_reg[idx_reg];
                end
                if (idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DECIDE:
            begin
                pobj_next  = '0;
                prsc_next  = '0;
                plast_next = 1'b1;
                pst_next   = ST_DONE;
                unique case (cmd_reg.op)
                    OP_ADD:
                    begin
                        used_clr = mfound_reg;
                        add_wr   = ffound_reg;
                        pst_next = ffound_reg ? ST_DONE : ST_FULL;
                    end
                    OP_REMOVE:
                    begin
                        used_clr = mfound_reg;
                        pst_next = mfound_reg ? ST_DONE : ST_NO_ENTRY;
                    end
                    OP_REFRESH:
                    begin
                        exp_wr   = mfound_reg;
                        pst_next = mfound_reg ? ST_DONE : ST_NO_ENTRY;
                    end
                    OP_TICK:
                    begin
                        if (bfound_reg)
                        begin
                            done_set       = 1'b1;
                            fired_any_next = 1'b1;
                            pst_next       = ST_EXPIRED;
                            pobj_next      = bobj_reg;
                            prsc_next      = brsc_reg;
                            plast_next     = 1'b0;
                        end
                        else
                        begin
                            pst_next = fired_any_reg ? ST_DONE : ST_NONE_DUE;
                        end
                    end
                    default:
                    begin
                        pst_next = ST_DONE;
                    end
                endcase
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = pst_reg;
                    fobj_next      = pobj_reg;
                    frsc_next      = prsc_reg;
                    last_next      = plast_reg;
                    if (plast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next    = '0;
                        bfound_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                used_reg[i] <= 1'b0;
                done_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            // add wins when it reuses the slot it just dropped
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (add_wr && (fidx_reg == IDX_W'(i)))
                begin
                    used_reg[i] <= 1'b1;
                end
                else if (used_clr && (midx_reg == IDX_W'(i)))
                begin
                    used_reg[i] <= 1'b0;
                end
            end
            if (done_clr)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    done_reg[i] <= 1'b0;
                end
            end
            else if (done_set)
            begin
                done_reg[bidx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        mfound_reg    <= mfound_next;
        midx_reg      <= midx_next;
        mper_reg      <= mper_next;
        ffound_reg    <= ffound_next;
        fidx_reg      <= fidx_next;
        bfound_reg    <= bfound_next;
        bidx_reg      <= bidx_next;
        bexp_reg      <= bexp_next;
        bobj_reg      <= bobj_next;
        brsc_reg      <= brsc_next;
        fired_any_reg <= fired_any_next;
        pst_reg       <= pst_next;
        pobj_reg      <= pobj_next;
        prsc_reg      <= prsc_next;
        plast_reg     <= plast_next;
        status_reg    <= status_next;
        fobj_reg      <= fobj_next;
        frsc_reg      <= frsc_next;
        last_reg      <= last_next;
        if (add_wr)
        begin
            obj_reg[fidx_reg] <= cmd_reg.obj_handle;
            rsc_reg[fidx_reg] <= cmd_reg.res_number;
            per_reg[fidx_reg] <= cmd_reg.period;
            exp_reg[fidx_reg] <= sat_add48(cmd_reg.now, cmd_reg.period);
        end
        else if (exp_wr)
        begin
            exp_reg[midx_reg] <= sat_add48(cmd_reg.now, mper_reg);
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign fired_object   = fobj_reg;
    assign fired_resource = frsc_reg;
    assign last           = last_reg;

endmodule

>>> hw/rtl/periodic_notify_timer_table.sv
// Table of 16 periodic deadlines keyed by (obj_handle, res_number). A request
// transfer is add (0), remove (1), refresh (2) or tick (3). Add, remove and
// refresh each give one response transfer with last set, status done, table
// full or no such entry. A tick gives one status-expired transfer per due
// entry (expiry <= now), oldest expiry first, lower slot first on ties, then a
// closing transfer with last set and status done or nothing expired. Due
// entries fire again on every tick until refreshed or removed. Expiry is
// now + period, clamped at 2^48-1. Timing: a front end queues up to two
// requests; the back end walks the slot table one slot per clock. Add,
// remove and refresh walk the table once; a tick walks the whole table
// once per reported entry and once more for its closing transfer.
// The response register holds a result while the back end waits for it to
// be taken.
module periodic_notify_timer_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] obj_handle,
    input  logic [15:0] res_number,
    input  logic [15:0] period,
    input  logic [47:0] now,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [15:0] fired_object,
    output logic [15:0] fired_resource,
    output logic        last
);
    import pntt_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // front: request transfer, decode, two-deep queue
    pntt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .obj_handle (obj_handle),
        .res_number (res_number),
        .period     (period),
        .now        (now),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop)
    );

    // back: slot table, walk sequencer, response register
    pntt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .fired_object   (fired_object),
        .fired_resource (fired_resource),
        .last           (last)
    );

`ifndef ASSERT_OFF
    // an expired-entry report never closes a tick
    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_EXPIRED) |-> !last)
        else $error("expired report marked last");

    // only expired reports carry a key
    a_key_only_on_expired: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_EXPIRED) |-> (fired_object == '0) && (fired_resource == '0))
        else $error("key on non-expired response");

    // every non-expired response ends its request
    a_closing_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_EXPIRED) |-> last)
        else $error("non-expired response not last");
`endif

endmodule

>>> tb/tb_periodic_notify_timer_table.sv
module tb_periodic_notify_timer_table;
    timeunit 1ns;
    timeprecision 1ps;
    import pntt_pkg::*;

    // One table response as seen on the response port.
    typedef struct {
        status_t     status;
        logic [15:0] obj;
        logic [15:0] rsc;
        logic        last;
    } timer_rsp_t;

    // Shadow of the deadline table. It predicts responses for each accepted
    // request and checks the responses in order.
    class timer_table_board;
        bit          used [ENTRIES];
        logic [15:0] obj_q [ENTRIES];
        logic [15:0] rsc_q [ENTRIES];
        logic [15:0] per_q [ENTRIES];
        logic [47:0] exp_q [ENTRIES];
        timer_rsp_t  pending [$];
        int          errors;

        function new();
            foreach (used[i]) used[i] = 0;
            errors = 0;
        endfunction

        function logic [47:0] clamp_sum(logic [47:0] a, logic [15:0] p);
            logic [48:0] s;
            s = {1'b0, a} + {33'b0, p};
            return s[48] ? {48{1'b1}} : s[47:0];
        endfunction

        function int lookup(logic [15:0] o, logic [15:0] r);
            for (int i = 0; i < ENTRIES; i++)
                if (used[i] && obj_q[i] == o && rsc_q[i] == r) return i;
            return -1;
        endfunction

        function void push(status_t st, logic [15:0] o, logic [15:0] r, logic l);
            timer_rsp_t t;
            t.status = st; t.obj = o; t.rsc = r; t.last = l;
            pending.push_back(t);
        endfunction

        function int occupancy();
            int n;
            n = 0;
            foreach (used[i]) n += used[i];
            return n;
        endfunction

        function void note_request(op_t op, logic [15:0] o, logic [15:0] r,
                                   logic [15:0] p, logic [47:0] t);
            int s;
            int best;
            int n;
            bit fired [ENTRIES];
            s = lookup(o, r);
            case (op)
                OP_ADD:
                begin
                    if (s >= 0) used[s] = 0;
                    s = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!used[i] && s < 0) s = i;
                    if (s < 0) push(ST_FULL, 0, 0, 1);
                    else
                    begin
                        used[s] = 1; obj_q[s] = o; rsc_q[s] = r; per_q[s] = p;
                        exp_q[s] = clamp_sum(t, p);
                        push(ST_DONE, 0, 0, 1);
                    end
                end
                OP_REMOVE, OP_REFRESH:
                begin
                    if (s < 0) push(ST_NO_ENTRY, 0, 0, 1);
                    else
                    begin
                        if (op == OP_REMOVE) used[s] = 0;
                        else exp_q[s] = clamp_sum(t, per_q[s]);
                        push(ST_DONE, 0, 0, 1);
                    end
                end
                default:
                begin
                    foreach (fired[i]) fired[i] = 0;
                    n = 0;
                    forever
                    begin
                        best = -1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (used[i] && !fired[i] && t >= exp_q[i] &&
                                (best < 0 || exp_q[i] < exp_q[best])) best = i;
                        if (best < 0) break;
                        fired[best] = 1;
                        push(ST_EXPIRED, obj_q[best], rsc_q[best], 0);
                        n++;
                    end
                    push(n > 0 ? ST_DONE : ST_NONE_DUE, 0, 0, 1);
                end
            endcase
        endfunction

        function void check_response(timer_rsp_t got);
            timer_rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response st=%0d obj=%h rsc=%h last=%b",
                         $time, got.status, got.obj, got.rsc, got.last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.obj !== e.obj)
            begin
                $display("%0t: fired_object exp %h got %h", $time, e.obj, got.obj);
                errors++;
            end
            if (got.rsc !== e.rsc)
            begin
                $display("%0t: fired_resource exp %h got %h", $time, e.rsc, got.rsc);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $display("%0t: last exp %b got %b", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [15:0] obj_handle;
    logic [15:0] res_number;
    logic [15:0] period;
    logic [47:0] now;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [2:0]  status;
    logic [15:0] fired_object;
    logic [15:0] fired_resource;
    logic        last;

    periodic_notify_timer_table dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .obj_handle     (obj_handle),
        .res_number     (res_number),
        .period         (period),
        .now            (now),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .fired_object   (fired_object),
        .fired_resource (fired_resource),
        .last           (last)
    );

    timer_table_board board;
    longint unsigned  cycles;
    bit               stim_done;
    bit               rsp_quiet;   // stretch with no receiver stalls
    logic [47:0]      uptime;      // running clock used by most requests
    logic [15:0]      key_obj [8]; // small key pool so hits are common
    logic [15:0]      key_rsc [8];

    // Worst case per request: tick with 16 due entries is 17 table walks,
    // every response stalled for the longest drawn wait, longest sender gap.
    localparam longint unsigned CYCLE_LIMIT = 400 * (17 * 40 + 17 * 18) * 3;

    initial
    begin
        clk = 0;
        forever
        begin
            #2 clk = 1;
            #2 clk = 0;
        end
    end

    initial
    begin
        board = new();
        rst_n = 0;
        req_valid = 0;
        req_type = OP_TICK;
        obj_handle = 0;
        res_number = 0;
        period = 0;
        now = 0;
        rsp_stall = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end
    initial cycles = 0;

    // Response side: sample transfers at the edge, then redraw the stall.
    // A stall is held until its drawn wait runs out.
    initial
    begin : rsp_side
        timer_rsp_t got;
        int wait_n;
        wait_n = 0;
        rsp_quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                got.status = status;
                got.obj = fired_object;
                got.rsc = fired_resource;
                got.last = last;
                board.check_response(got);
                wait_n = rsp_quiet ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 40) == 0) rsp_quiet = !rsp_quiet;
            end
            if (wait_n > 0)
            begin
                rsp_stall <= 1;
                wait_n--;
            end
            else
                rsp_stall <= 0;
        end
    end

    // Present one request and hold it until the transfer happens; the model
    // is updated at that edge. Valid stays up if the caller sends back to back.
    task automatic send_request(op_t op, logic [15:0] o, logic [15:0] r,
                                logic [15:0] p, logic [47:0] t, int gap);
        req_valid <= 1;
        req_type <= op;
        obj_handle <= o;
        res_number <= r;
        period <= p;
        now <= t;
        do @(posedge clk); while (req_stall);
        board.note_request(op, o, r, p, t);
        if (gap > 0)
        begin
            req_valid <= 0;
            req_type <= 2'($urandom_range(0, 3));
            now <= 48'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    // Random request against the key pool; time mostly moves forward.
    task automatic random_request();
        int k;
        int sel;
        logic [15:0] p;
        k = $urandom_range(0, 7);
        sel = $urandom_range(0, 99);
        uptime = uptime + 48'($urandom_range(0, 300));
        p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        if (sel < 35)
            send_request(OP_ADD, key_obj[k], key_rsc[k], p, uptime, pick_gap());
        else if (sel < 48)
            send_request(OP_REMOVE, key_obj[k], key_rsc[k], p, uptime, pick_gap());
        else if (sel < 62)
            send_request(OP_REFRESH, key_obj[k], key_rsc[k], p, uptime, pick_gap());
        else if (sel < 67)
            // fully random keys and times: misses and far-off clocks
            send_request(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         16'($urandom), 48'({$urandom, $urandom}), pick_gap());
        else
            send_request(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), uptime,
                         pick_gap());
    endtask

    initial
    begin : req_side
        logic [47:0] top;
        top = {48{1'b1}};
        stim_done = 0;
        uptime = 1000;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: empty tick, misses, saturation, ties, full table.
        send_request(OP_TICK, 0, 0, 0, 0, 1);
        send_request(OP_REMOVE, 16'hffff, 16'hffff, 0, 0, 0);
        send_request(OP_REFRESH, 16'h1234, 16'h0000, 16'hffff, top, 2);
        send_request(OP_ADD, 16'hffff, 16'hffff, 16'hffff, top - 48'd5, 0);
        send_request(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 48'd10, 0);
        send_request(OP_ADD, 16'h0001, 16'h0000, 16'h0005, 48'd5, 0);
        send_request(OP_TICK, 0, 0, 0, 48'd10, 0);
        send_request(OP_TICK, 0, 0, 0, top, 0);
        send_request(OP_REFRESH, 16'h0001, 16'h0000, 0, 48'd100, 0);
        send_request(OP_ADD, 16'h0000, 16'h0000, 16'h0050, 48'd20, 0);
        send_request(OP_TICK, 0, 0, 0, 48'd105, 3);
        send_request(OP_REMOVE, 16'hffff, 16'hffff, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send_request(OP_ADD, 16'(16'h0100 + i), 16'h00aa, 16'(i % 3), 48'd50, 0);
        send_request(OP_ADD, 16'h0200, 16'h0200, 16'h0001, 48'd1, 0);
        send_request(OP_ADD, 16'h0105, 16'h00aa, 16'h0000, 48'd200, 0);
        send_request(OP_TICK, 0, 0, 0, top, 0);
        for (int i = 0; i < 16; i++)
            send_request(OP_REMOVE, 16'(16'h0100 + i), 16'h00aa, 0, 0, 0);
        send_request(OP_REMOVE, 16'h0000, 16'h0000, 0, 0, 0);
        send_request(OP_REMOVE, 16'h0001, 16'h0000, 0, 0, 1);

        // Random part over a small key pool with random content.
        for (int i = 0; i < 8; i++)
        begin
            key_obj[i] = 16'($urandom);
            key_rsc[i] = 16'($urandom);
        end
        for (int n = 0; n < 160; n++)
        begin
            if (n % 60 == 30)
                // fill the table with fresh keys to reach the full case
                for (int j = 0; j < 17; j++)
                    send_request(OP_ADD, 16'($urandom), 16'($urandom),
                                 16'($urandom_range(0, 50)), uptime, pick_gap());
            random_request();
            if (n % 60 == 45)
            begin
                // remove every key of the pool from the table
                for (int j = 0; j < 8; j++)
                    send_request(OP_REMOVE, key_obj[j], key_rsc[j], 0, uptime, 0);
                send_request(OP_TICK, 0, 0, 0, uptime, 1);
            end
        end
        req_valid <= 0;
        stim_done = 1;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pntt_pkg.sv
hw/rtl/pntt_front.sv
hw/rtl/pntt_back.sv
hw/rtl/periodic_notify_timer_table.sv
tb/tb_periodic_notify_timer_table.sv
